// File: sv/ltal_pkg.sv
// ----------------------------------------------------------------------------
// ltal_pkg
// Shared widths, constants and types of the packed line table decoder.
// ----------------------------------------------------------------------------
package ltal_pkg;

  localparam int LineW    = 32;
  localparam int WordW    = 30;
  localparam int CurWordW = 31;
  localparam int OffW     = 24;
  localparam int ByteW    = 8;
  localparam int CntW     = 4;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  localparam logic [OffW-1:0] LIMIT_OFFSET  = 24'd9999999;
  localparam logic [3:0]      ESCAPE_NIBBLE = 4'h8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_LINE  = 2'd0,
    REG_START_WORD  = 2'd1,
    REG_STOP_WORD   = 2'd2,
    REG_TARGET_WORD = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [LineW-1:0] start_line;
    logic [WordW-1:0] start_word;
    logic [WordW-1:0] stop_word;
    logic [WordW-1:0] target_word;
  } cfg_t;

endpackage

// File: sv/ltal_in_if.sv
// ----------------------------------------------------------------------------
// ltal_in_if
// Table byte channel: one raw byte of the packed table per transaction.
// ----------------------------------------------------------------------------
interface ltal_in_if;
  logic                     valid;
  logic                     ready;
  logic [ltal_pkg::ByteW-1:0] table_byte;
  logic                     restart;

  modport source (output valid, output table_byte, output restart, input ready);
  modport sink   (input valid, input table_byte, input restart, output ready);
endinterface

// File: sv/ltal_out_if.sv
// ----------------------------------------------------------------------------
// ltal_out_if
// Result channel: one transaction per completed table entry.
// ----------------------------------------------------------------------------
interface ltal_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ltal_pkg::LineW-1:0] entry_line;
  logic signed [ltal_pkg::LineW-1:0] best_line;
  logic                              finished;

  modport source (output valid, output entry_line, output best_line, output finished,
                  input ready);
  modport sink   (input valid, input entry_line, input best_line, input finished,
                  output ready);
endinterface

// File: sv/ltal_cfg_if.sv
// ----------------------------------------------------------------------------
// ltal_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ltal_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ltal_pkg::CfgIdxW-1:0]  index;
  logic [ltal_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/ltal_cfg_regs.sv
// ----------------------------------------------------------------------------
// ltal_cfg_regs
// Configuration register bank, written one register per transaction.
// ----------------------------------------------------------------------------
module ltal_cfg_regs (
  input  logic         clk,
  input  logic         rst,
  ltal_cfg_if.sink     cfg,
  output ltal_pkg::cfg_t regs
);
  import ltal_pkg::*;

  cfg_reg_t idx;

  assign cfg.ready = 1'b1;
  assign idx       = cfg_reg_t'(cfg.index);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (idx)
        REG_START_LINE:  regs.start_line  <= cfg.data[LineW-1:0];
        REG_START_WORD:  regs.start_word  <= cfg.data[WordW-1:0];
        REG_STOP_WORD:   regs.stop_word   <= cfg.data[WordW-1:0];
        REG_TARGET_WORD: regs.target_word <= cfg.data[WordW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: sv/line_table_address_to_line_unit.sv
// ----------------------------------------------------------------------------
// line_table_address_to_line_unit
// Packed line-number table decoder with nearest-line lookup for one procedure.
// ----------------------------------------------------------------------------
// The unit takes one table byte per clock cycle while input ready is high.
// A short entry is one byte, an escaped entry (line delta nibble 8) is
// three bytes. The result of an entry is held in the output register from
// the cycle after its last byte is accepted; the decode state is updated in
// that same cycle by the line and word adds, the offset subtract, a few
// compares and the phase update, so bytes follow back to back. Input ready
// drops only while a result sits in the output register and is not taken.
// Configuration writes are taken in any cycle and should be made while the
// unit is idle. Set restart with the first byte of each run.
module line_table_address_to_line_unit (
  input  logic      clk,
  input  logic      rst,
  ltal_cfg_if.sink  cfg,
  ltal_in_if.sink   table_in,
  ltal_out_if.source result
);
  import ltal_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_HIGH   = 2'd1,
    PH_LOW    = 2'd2
  } phase_t;

  cfg_t regs;

  ltal_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // decode state
  phase_t              phase, phase_next;
  logic [CntW-1:0]     pending_count, pending_count_next;
  logic [ByteW-1:0]    delta_high, delta_high_next;
  logic [LineW-1:0]    current_line, current_line_next;
  logic [CurWordW-1:0] current_word, current_word_next;
  logic [LineW-1:0]    best_found_line, best_found_line_next;
  logic [OffW-1:0]     near_offset, near_offset_next;
  logic                done_flag, done_flag_next;

  // state after an optional restart
  phase_t              ph_eff;
  logic [CntW-1:0]     pend_eff;
  logic [ByteW-1:0]    dhigh_eff;
  logic [LineW-1:0]    line_eff;
  logic [CurWordW-1:0] word_eff;
  logic [LineW-1:0]    best_line_eff;
  logic [OffW-1:0]     best_off_eff;
  logic                done_eff;

  logic                accept;
  logic                emit;
  logic [LineW-1:0]    delta;
  logic [CntW-1:0]     pend_sel;
  logic [LineW-1:0]    new_line;
  logic [CurWordW-1:0] target_ext;
  logic [CurWordW-1:0] diff;
  logic [CurWordW-1:0] new_word;
  logic [CurWordW-1:0] stop_ext;
  logic [CurWordW-1:0] raw_word;

  assign table_in.ready = !result.valid || result.ready;
  assign accept         = table_in.valid && table_in.ready;
  assign target_ext     = {1'b0, regs.target_word};
  assign stop_ext       = {1'b0, regs.stop_word};

  always_comb begin
    if (table_in.restart) begin
      ph_eff        = PH_HEADER;
      pend_eff      = '0;
      dhigh_eff     = '0;
      line_eff      = regs.start_line;
      word_eff      = {1'b0, regs.start_word};
      best_line_eff = regs.start_line;
      best_off_eff  = LIMIT_OFFSET;
      done_eff      = 1'b0;
    end else begin
      ph_eff        = phase;
      pend_eff      = pending_count;
      dhigh_eff     = delta_high;
      line_eff      = current_line;
      word_eff      = current_word;
      best_line_eff = best_found_line;
      best_off_eff  = near_offset;
      done_eff      = done_flag;
    end
  end

  always_comb begin
    phase_next           = ph_eff;
    pending_count_next   = pend_eff;
    delta_high_next      = dhigh_eff;
    current_line_next    = line_eff;
    current_word_next    = word_eff;
    best_found_line_next = best_line_eff;
    near_offset_next     = best_off_eff;
    done_flag_next       = done_eff;
    emit                 = 1'b0;
    delta                = {{(LineW-ByteW-ByteW){dhigh_eff[ByteW-1]}}, dhigh_eff,
                            table_in.table_byte};
    pend_sel             = pend_eff;

    if (!done_eff) begin
      case (ph_eff)
        PH_HIGH: begin
          delta_high_next = table_in.table_byte;
          phase_next      = PH_LOW;
        end
        PH_LOW: begin
          emit = 1'b1;
        end
        default: begin
          // phase 3 is treated as a header byte
          if (word_eff >= stop_ext) begin
            done_flag_next = 1'b1;
          end else begin
            pend_sel           = table_in.table_byte[CntW-1:0];
            pending_count_next = pend_sel;
            if (table_in.table_byte[ByteW-1:CntW] == ESCAPE_NIBBLE) begin
              phase_next = PH_HIGH;
            end else begin
              delta = {{(LineW-CntW){table_in.table_byte[ByteW-1]}},
                       table_in.table_byte[ByteW-1:CntW]};
              emit  = 1'b1;
            end
          end
        end
      endcase
    end

    new_line = line_eff + delta;
    diff     = target_ext - word_eff;
    raw_word = word_eff + CurWordW'(pend_sel) + CurWordW'(1);
    new_word = raw_word;

    if (emit) begin
      current_line_next = new_line;
      if (target_ext >= word_eff && diff < {{(CurWordW-OffW){1'b0}}, best_off_eff}) begin
        near_offset_next     = diff[OffW-1:0];
        best_found_line_next = new_line;
      end
      current_word_next = new_word;
      done_flag_next    = new_word >= stop_ext;
      phase_next        = PH_HEADER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      pending_count   <= '0;
      delta_high      <= '0;
      current_line    <= '0;
      current_word    <= '0;
      best_found_line <= '0;
      near_offset     <= LIMIT_OFFSET;
      done_flag       <= 1'b0;
      result.valid    <= 1'b0;
    end else begin
      if (accept && emit) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      if (accept) begin
        phase           <= phase_next;
        pending_count   <= pending_count_next;
        delta_high      <= delta_high_next;
        current_line    <= current_line_next;
        current_word    <= current_word_next;
        best_found_line <= best_found_line_next;
        near_offset     <= near_offset_next;
        done_flag       <= done_flag_next;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      result.entry_line <= current_line_next;
      result.best_line  <= best_found_line_next;
      result.finished   <= done_flag_next;
    end
  end

endmodule

// File: sv/ltal_checker.sv
// ----------------------------------------------------------------------------
// ltal_checker
// Port-level checks of the line table decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ltal_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [ltal_pkg::LineW-1:0] out_entry_line,
  input logic signed [ltal_pkg::LineW-1:0] out_best_line,
  input logic                              out_finished
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_entry_line) &&
      $stable(out_best_line) && $stable(out_finished))
    else $error("result changed while stalled");

  // no result straight after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // a full, untaken output register blocks new table bytes
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("byte accepted while result stalled");

  // free output register means the unit takes bytes
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

endmodule

bind line_table_address_to_line_unit ltal_checker u_ltal_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (table_in.valid),
  .in_ready       (table_in.ready),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .out_entry_line (result.entry_line),
  .out_best_line  (result.best_line),
  .out_finished   (result.finished)
);

// File: dv/tb_line_table_address_to_line_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_table_address_to_line_unit
// Self-checking bench for the packed line table decoder. A short directed
// table covers register extremes, escaped and short entries, restarts and the
// stop conditions. Random table runs with random valid/ready gaps follow.
// Each result is compared to its pinned value or an in-bench decode.
// ----------------------------------------------------------------------------
module tb_line_table_address_to_line_unit;
  import ltal_pkg::*;

  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_LIMIT  = 2000;
  localparam int ITEM_GOAL    = 1000;
  localparam int QUIET_AFTER  = 850;
  localparam int PRESSURE_AT  = 300;
  localparam int RUN_BYTES    = 80;
  localparam int MAX_SHOWN    = 20;

  localparam logic [1:0] PH_HEADER   = 2'd0;
  localparam logic [1:0] PH_DELTA_HI = 2'd1;
  localparam logic [1:0] PH_DELTA_LO = 2'd2;

  typedef struct packed {
    logic signed [LineW-1:0] entry_line;
    logic signed [LineW-1:0] best_line;
    logic                    finished;
  } entry_result_t;

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

  typedef struct {
    row_kind_t     kind;
    logic          restart;
    logic [7:0]    tbyte;
    bit            pinned;
    entry_result_t want;
    cfg_t          regs;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  ltal_cfg_if cfg_bus ();
  ltal_in_if  byte_bus ();
  ltal_out_if res_bus ();

  line_table_address_to_line_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_bus),
    .table_in (byte_bus),
    .result   (res_bus)
  );

  always #5 clk = ~clk;

  // decoder state mirrored by the bench
  cfg_t              shadow;
  logic [1:0]        st_phase;
  logic [3:0]        st_count;
  logic [7:0]        st_delta_hi;
  logic [LineW-1:0]  st_line;
  logic [30:0]       st_word;
  logic [LineW-1:0]  st_best;
  logic [31:0]       st_best_off;
  bit                st_done;

  entry_result_t pending_results[$];

  bit            pin_on;
  entry_result_t pin_want;
  bit            idling;
  bit            hold_pending;

  int errors;
  int useful_items;
  int entries_checked;
  int escapes_seen;
  int done_events;
  int runs;
  int stall_cycles;

  task automatic report(input string msg);
    if (errors < MAX_SHOWN) $display("ERROR %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic close_entry(input logic [31:0] delta, output entry_result_t r);
    logic [31:0] gap;
    st_line = st_line + delta;
    gap = {2'b00, shadow.target_word} - {1'b0, st_word};
    if ({1'b0, shadow.target_word} >= st_word && gap < st_best_off) begin
      st_best_off = gap;
      st_best = st_line;
    end
    st_word = st_word + {27'd0, st_count} + 31'd1;
    st_done = st_word >= {1'b0, shadow.stop_word};
    st_phase = PH_HEADER;
    r.entry_line = st_line;
    r.best_line = st_best;
    r.finished = st_done;
    if (st_done) done_events++;
  endtask

  task automatic decode_byte(input logic rs, input logic [7:0] b, output bit made,
                             output bit skipped, output entry_result_t r);
    logic [15:0] raw;
    logic [3:0]  nib;
    made = 1'b0;
    skipped = 1'b0;
    r = '0;
    if (rs) begin
      st_phase = PH_HEADER;
      st_count = '0;
      st_delta_hi = '0;
      st_line = shadow.start_line;
      st_word = {1'b0, shadow.start_word};
      st_best = shadow.start_line;
      st_best_off = {8'd0, LIMIT_OFFSET};
      st_done = 1'b0;
    end
    if (st_done) begin
      skipped = 1'b1;
    end else if (st_phase == PH_DELTA_HI) begin
      st_delta_hi = b;
      st_phase = PH_DELTA_LO;
    end else if (st_phase == PH_DELTA_LO) begin
      raw = {st_delta_hi, b};
      close_entry({{16{raw[15]}}, raw}, r);
      made = 1'b1;
    end else if (st_word >= {1'b0, shadow.stop_word}) begin
      // nothing left to decode, the header is dropped
      st_done = 1'b1;
      skipped = 1'b1;
    end else begin
      st_count = b[3:0];
      nib = b[7:4];
      if (nib == ESCAPE_NIBBLE) begin
        st_phase = PH_DELTA_HI;
        escapes_seen++;
      end else begin
        close_entry({{28{nib[3]}}, nib}, r);
        made = 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin : sample
    entry_result_t got_r;
    entry_result_t want_r;
    bit made;
    bit skipped;
    if (rst) begin
      shadow = '0;
      st_phase = PH_HEADER;
      st_count = '0;
      st_delta_hi = '0;
      st_line = '0;
      st_word = '0;
      st_best = '0;
      st_best_off = {8'd0, LIMIT_OFFSET};
      st_done = 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        entries_checked++;
        if (pending_results.size() == 0) begin
          report($sformatf("unexpected result line %0d", res_bus.entry_line));
        end else begin
          want_r = pending_results.pop_front();
          if (res_bus.entry_line !== want_r.entry_line)
            report($sformatf("entry_line got %0d expected %0d",
                             res_bus.entry_line, want_r.entry_line));
          if (res_bus.best_line !== want_r.best_line)
            report($sformatf("best_line got %0d expected %0d",
                             res_bus.best_line, want_r.best_line));
          if (res_bus.finished !== want_r.finished)
            report($sformatf("finished got %b expected %b",
                             res_bus.finished, want_r.finished));
        end
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_reg_t'(cfg_bus.index))
          REG_START_LINE:  shadow.start_line = cfg_bus.data;
          REG_START_WORD:  shadow.start_word = cfg_bus.data[WordW-1:0];
          REG_STOP_WORD:   shadow.stop_word = cfg_bus.data[WordW-1:0];
          REG_TARGET_WORD: shadow.target_word = cfg_bus.data[WordW-1:0];
          default: ;
        endcase
      end
      if (byte_bus.valid && !byte_bus.ready) stall_cycles++;
      if (byte_bus.valid && byte_bus.ready) begin
        decode_byte(byte_bus.restart, byte_bus.table_byte, made, skipped, got_r);
        if (!skipped) useful_items++;
        if (made || pin_on) pending_results.push_back(pin_on ? pin_want : got_r);
      end
    end
  end

  // result side: random back-pressure plus one long hold
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        res_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (idling && $urandom_range(0, 5) == 0) begin
        res_bus.ready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic rs, input logic [7:0] b, input bit pinned,
                           input entry_result_t want);
    @(negedge clk);
    if (idling && $urandom_range(0, 4) == 0) begin
      byte_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    byte_bus.valid <= 1'b1;
    byte_bus.table_byte <= b;
    byte_bus.restart <= rs;
    pin_on = pinned;
    pin_want = want;
    do @(posedge clk); while (!byte_bus.ready);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] d);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= d;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  task automatic apply_config(input cfg_t c);
    @(negedge clk);
    byte_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    // a dropped header may still be in flight after the last result
    repeat (4) @(negedge clk);
    write_reg(REG_START_LINE, c.start_line);
    write_reg(REG_START_WORD, {2'($urandom), c.start_word});
    write_reg(REG_STOP_WORD, {2'($urandom), c.stop_word});
    write_reg(REG_TARGET_WORD, {2'($urandom), c.target_word});
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic stim_row_t cfg_row(input logic [31:0] sl, input logic [29:0] sw,
                                        input logic [29:0] ew, input logic [29:0] tw);
    stim_row_t row;
    row = '{kind: ROW_CFG, restart: 1'b0, tbyte: 8'h00, pinned: 1'b0, want: '0,
            regs: '0};
    row.regs = '{start_line: sl, start_word: sw, stop_word: ew, target_word: tw};
    return row;
  endfunction

  function automatic stim_row_t byte_row(input logic rs, input logic [7:0] b);
    stim_row_t row;
    row = '{kind: ROW_BYTE, restart: rs, tbyte: b, pinned: 1'b0, want: '0, regs: '0};
    return row;
  endfunction

  function automatic stim_row_t pin_row(input logic rs, input logic [7:0] b,
                                        input logic [31:0] el, input logic [31:0] bl,
                                        input logic fin);
    stim_row_t row;
    row = byte_row(rs, b);
    row.pinned = 1'b1;
    row.want = '{entry_line: el, best_line: bl, finished: fin};
    return row;
  endfunction

  function automatic logic stray_restart();
    return $urandom_range(0, 49) == 0;
  endfunction

  initial begin : stimulus
    stim_row_t     script[$];
    cfg_t          c;
    entry_result_t none;
    int            span;
    int            sent;
    int            drain;
    bit            first;
    bit            pressure_asked;
    logic [3:0]    nib;
    int            pick;

    rst = 1'b1;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_START_LINE;
    cfg_bus.data = '0;
    byte_bus.valid = 1'b0;
    byte_bus.table_byte = '0;
    byte_bus.restart = 1'b0;
    pin_on = 1'b0;
    pin_want = '0;
    none = '0;
    idling = 1'b1;
    hold_pending = 1'b0;
    pressure_asked = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // out of reset all words are zero, so the first header is dropped
    script.push_back(byte_row(1'b0, 8'h10));
    script.push_back(cfg_row(32'd100, 30'd0, 30'd20, 30'd5));
    script.push_back(pin_row(1'b1, 8'h10, 32'd101, 32'd101, 1'b0));
    script.push_back(pin_row(1'b0, 8'hF0, 32'd100, 32'd100, 1'b0));
    script.push_back(pin_row(1'b0, 8'h7F, 32'd107, 32'd107, 1'b0));
    script.push_back(byte_row(1'b0, 8'h81));
    script.push_back(byte_row(1'b0, 8'h7F));
    script.push_back(pin_row(1'b0, 8'hFF, 32'd32874, 32'd107, 1'b1));
    script.push_back(byte_row(1'b0, 8'h00));
    script.push_back(byte_row(1'b1, 8'h8F));
    script.push_back(byte_row(1'b0, 8'h80));
    script.push_back(pin_row(1'b0, 8'h00, -32'sd32668, -32'sd32668, 1'b0));
    script.push_back(pin_row(1'b0, 8'h90, -32'sd32675, -32'sd32668, 1'b0));
    script.push_back(pin_row(1'b0, 8'h02, -32'sd32675, -32'sd32668, 1'b1));
    script.push_back(cfg_row(32'h7FFF_FFFF, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 30'h3FFF_FFFF));
    script.push_back(byte_row(1'b1, 8'h10));
    script.push_back(cfg_row(32'h7FFF_FFFF, 30'h3FFF_FFF0, 30'h3FFF_FFFF, 30'h3FFF_FFFF));
    script.push_back(pin_row(1'b1, 8'h1F, 32'h8000_0000, 32'h8000_0000, 1'b1));
    script.push_back(cfg_row(32'h8000_0000, 30'd0, 30'h3FFF_FFFF, 30'h3FFF_FFFF));
    script.push_back(pin_row(1'b1, 8'hF0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    // target exactly at the offset limit, then one word under it
    script.push_back(cfg_row(32'd5, 30'd0, 30'd100, 30'd9999999));
    script.push_back(byte_row(1'b1, 8'h10));
    script.push_back(byte_row(1'b0, 8'h00));
    script.push_back(byte_row(1'b0, 8'h80));
    script.push_back(byte_row(1'b1, 8'h30));
    script.push_back(byte_row(1'b0, 8'h8F));
    script.push_back(byte_row(1'b0, 8'hFF));
    script.push_back(byte_row(1'b0, 8'hFF));

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        apply_config(script[i].regs);
      end else begin
        send_byte(script[i].restart, script[i].tbyte, script[i].pinned, script[i].want);
      end
    end

    while (useful_items < ITEM_GOAL) begin
      runs++;
      span = $urandom_range(1, 120);
      case ($urandom_range(0, 5))
        0: c.start_word = '0;
        1: c.start_word = 30'h3FFF_FFFF - 30'(span);
        default: c.start_word = 30'($urandom_range(0, 32'h3FFF_FFFF - span));
      endcase
      c.stop_word = c.start_word + 30'(span);
      if ($urandom_range(0, 9) == 0) c.stop_word = c.start_word - 30'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0: c.start_line = $urandom;
        1: c.start_line = 32'h7FFF_FFFF - $urandom_range(0, 40);
        2: c.start_line = 32'h8000_0000 + $urandom_range(0, 40);
        default: c.start_line = $urandom_range(0, 2000);
      endcase
      case ($urandom_range(0, 5))
        0: c.target_word = 30'($urandom);
        1: c.target_word = c.start_word - 30'($urandom_range(1, 10));
        2: c.target_word = c.start_word + 30'd9999990 + 30'($urandom_range(0, 20));
        default: c.target_word = c.start_word + 30'($urandom_range(0, span + 16));
      endcase
      apply_config(c);
      idling = (useful_items < QUIET_AFTER) && ($urandom_range(0, 3) != 0);
      if (useful_items >= PRESSURE_AT && !pressure_asked) begin
        pressure_asked = 1'b1;
        hold_pending = 1'b1;
      end

      first = 1'b1;
      sent = 0;
      while ((first || !st_done) && sent < RUN_BYTES) begin
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          send_byte(first || stray_restart(), {ESCAPE_NIBBLE, 4'($urandom)}, 1'b0, none);
          send_byte(stray_restart(), 8'($urandom), 1'b0, none);
          send_byte(stray_restart(), 8'($urandom), 1'b0, none);
          sent += 3;
        end else if (pick < 95) begin
          nib = 4'($urandom_range(0, 14));
          if (nib >= ESCAPE_NIBBLE) nib = nib + 4'd1;
          send_byte(first || stray_restart(), {nib, 4'($urandom)}, 1'b0, none);
          sent++;
        end else begin
          send_byte(first || stray_restart(), 8'($urandom), 1'b0, none);
          sent++;
        end
        first = 1'b0;
      end
      // trailing bytes follow; they are dropped once the table has finished
      repeat ($urandom_range(0, 2)) send_byte(1'b0, 8'($urandom), 1'b0, none);
    end

    @(negedge clk);
    byte_bus.valid <= 1'b0;
    idling = 1'b0;
    drain = 0;
    while (pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report($sformatf("%0d results never arrived", pending_results.size()));

    $display("covered %0d decoded bytes over %0d random runs, %0d entries checked",
             useful_items, runs, entries_checked);
    $display("%0d escaped deltas, %0d stop-word hits, %0d input stall cycles",
             escapes_seen, done_events, stall_cycles);
    if (errors == 0) begin
      $display("line_table_address_to_line_unit: match");
    end else begin
      $display("line_table_address_to_line_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout waiting for the decoder");
    $display("line_table_address_to_line_unit: mismatch");
    $finish;
  end

endmodule
